/* design/frama_pkg.sv */
// Package for the fractal adaptive moving average block.
// Holds the sequencer state type, the fixed-point constants and the reciprocal table.
// Used by the top level only; the RAM, multiplier and divider do not use it.
`default_nettype none
package frama_pkg;

  localparam int unsigned MaxHalf   = 32;
  localparam int unsigned PriceBits = 32;
  localparam int unsigned RingDepth = 2 * MaxHalf;
  localparam int unsigned RingAw    = $clog2(RingDepth);

  localparam logic [1:0] CfgHalfPeriod = 2'd0;
  localparam logic [1:0] CfgDecayCoef  = 2'd1;

  localparam logic [5:0]  HalfReset  = 6'd8;
  localparam logic [15:0] DecayReset = 16'hB666;  // -18842, k = -4.6 in Q4.12

  localparam logic [31:0] OneQ30   = 32'h4000_0000;
  localparam logic [31:0] TwoQ30   = 32'h8000_0000;
  localparam logic [16:0] AlphaOne = 17'h1_0000;
  localparam logic [3:0]  TaylorLast = 4'd12;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANGE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_LOG_CLASS,
    ST_LOG_MUL,
    ST_LOG_UPD,
    ST_EXP_MUL,
    ST_EXP_U,
    ST_TAY_MUL,
    ST_TAY_RCP,
    ST_TAY_FIX,
    ST_SQ_MUL,
    ST_SQ_UPD,
    ST_ROUND,
    ST_AVG_A,
    ST_AVG_B,
    ST_AVG_SUM,
    ST_DONE
  } state_e;

  // floor((2^32 - 1) / n); the estimate it gives is at most one below the true quotient.
  function automatic logic [31:0] recip(input logic [3:0] n);
    logic [31:0] r;
    unique case (n)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h7FFF_FFFF;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h3FFF_FFFF;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h1FFF_FFFF;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/frama_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module frama_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* design/frama_mul.sv */
// Shared signed 33x33 multiplier with a registered product.
// Depends on nothing but the clock; operands are chosen by the sequencer.
`default_nettype none
module frama_mul (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic             [63:0] p_o
);

  logic signed [65:0] prod;
  logic        [63:0] p_d, p_q;

  assign prod = a_i * b_i;
  assign p_d  = en_i ? prod[63:0] : p_q;
  assign p_o  = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

endmodule
`default_nettype wire

/* design/frama_div.sv */
// Restoring divider, one quotient bit per cycle, for (num << 29) / den.
// The caller guarantees a quotient below 2^32; uses no package items.
`default_nettype none
module frama_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [34:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic      [31:0] quo_o
);

  logic [32:0] rem_d, rem_q;
  logic [31:0] low_d, low_q, quo_d, quo_q;
  logic [4:0]  cnt_d, cnt_q;
  logic        busy_d, busy_q, done_d, done_q;
  logic [33:0] trial;
  logic [33:0] diff;
  logic        ge;

  assign trial = {rem_q, low_q[31]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i[34:3]};
      low_d  = {num_i[2:0], 29'd0};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[32:0] : trial[32:0];
      low_d = {low_q[30:0], 1'b0};
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

/* design/fractal_adaptive_moving_average.sv */
// Fractal adaptive moving average: top level with the sequencer and window ring.
// Depends on frama_pkg, frama_ram, frama_mul and frama_div.
//
// Usage:
//   The slave stream takes one price bar per word: close, low and high in
//   signed Q16.16. The master stream returns one word per bar: the average in
//   tdata and the warmed-up flag in tuser. The configuration port writes
//   half_period (index 0) and decay_coefficient (index 1) while the block is
//   idle; writing half_period restarts the window fill.
//   Highs and lows of the last 2*h bars sit in two ring memories, where h is
//   half_period clamped to 1..32. During the fill a bar goes from idle
//   straight to the done state, and its word is loaded into the output
//   register. After the fill the word comes from a scan of the ring for the
//   four extremes, the serial divider, the log squarings (skipped when the
//   range ratio is below 1 or at least 2), the Taylor terms, and set-up,
//   squaring, rounding and blending; the multiplying steps share one
//   multiplier. A zero full range skips the divider, log and exp.
//   The sequencer returns to idle as the word enters the output register.
//   Only one bar is in work at a time; s_axis_tready is high only when idle.
//   A finished result waits in an output register while the receiver stalls,
//   and the next bar is accepted meanwhile. Reset restores the register
//   defaults and an empty fill; ring contents need no clearing.
`default_nettype none
module fractal_adaptive_moving_average (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // close_price, low_price, high_price
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // average
  output logic             m_axis_tuser,   // warmed_up
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned Aw = frama_pkg::RingAw;

  frama_pkg::state_e state_d, state_q;

  logic [5:0]  hp_d, hp_q;
  logic [15:0] dc_d, dc_q;
  logic [6:0]  fill_d, fill_q;
  logic [Aw-1:0] head_d, head_q;
  logic [6:0]  cnt_d, cnt_q;
  logic        dv_d, dv_q;
  logic [5:0]  didx_d, didx_q;
  logic signed [31:0] ohm_d, ohm_q, nhm_d, nhm_q, olm_d, olm_q, nlm_d, nlm_q;
  logic [31:0] close_d, close_q, low_d, low_q, high_d, high_q;
  logic [32:0] r_d, r_q;
  logic [34:0] num_d, num_q;
  logic [31:0] m_d, m_q;
  logic [16:0] frac_d, frac_q;
  logic [3:0]  it_d, it_q;
  logic [30:0] u_d, u_q, term_d, term_q, x_d, x_q;
  logic [31:0] sum_d, sum_q;
  logic [3:0]  n_d, n_q;
  logic [16:0] alpha_d, alpha_q;
  logic [63:0] acc_d, acc_q;
  logic [31:0] prev_d, prev_q;
  logic [31:0] res_d, res_q;
  logic        resu_d, resu_q;
  logic        ov_d, ov_q;
  logic [31:0] od_d, od_q;
  logic        ou_d, ou_q;

  // Effective half period and full window length.
  logic [5:0] h;
  logic [6:0] twoh;
  assign h    = (hp_q == 6'd0) ? 6'd1 : ((hp_q > 6'd32) ? 6'd32 : hp_q);
  assign twoh = {h, 1'b0};

  logic in_acc;
  assign s_axis_tready = (state_q == frama_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Ring memories for highs and lows.
  logic          ram_we;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  logic [31:0]   hi_wdata, lo_wdata, hi_rdata, lo_rdata;
  logic [6:0]    pos;

  assign pos       = {1'b0, head_q} + cnt_q;
  assign ram_raddr = (pos >= twoh) ? 6'(pos - twoh) : pos[Aw-1:0];

  frama_ram #(.Width(32), .Depth(frama_pkg::RingDepth)) u_hi_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (hi_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (hi_rdata)
  );

  frama_ram #(.Width(32), .Depth(frama_pkg::RingDepth)) u_lo_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (lo_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (lo_rdata)
  );

  // Shared multiplier.
  logic               mul_en;
  logic signed [32:0] mul_a, mul_b;
  logic        [63:0] p;

  frama_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  // Serial divider for the dimension ratio.
  logic        div_start, div_done;
  logic [31:0] div_quo;

  frama_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (r_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Range arithmetic on the window extremes.
  logic signed [32:0] d1, d2, df;
  logic signed [31:0] fh, fl;
  logic [32:0] r1, r2, rf;
  logic [33:0] rsum;
  assign fh   = (ohm_q > nhm_q) ? ohm_q : nhm_q;
  assign fl   = (olm_q < nlm_q) ? olm_q : nlm_q;
  assign d1   = 33'(ohm_q) - 33'(olm_q);
  assign d2   = 33'(nhm_q) - 33'(nlm_q);
  assign df   = 33'(fh) - 33'(fl);
  assign r1   = (ohm_q > olm_q) ? d1 : 33'd0;
  assign r2   = (nhm_q > nlm_q) ? d2 : 33'd0;
  assign rf   = (fh > fl) ? df : 33'd0;
  assign rsum = {1'b0, r1} + {1'b0, r2};

  // Helpers for the other steps.
  logic [31:0] m2;
  logic [30:0] tx, q0, qn;
  logic [34:0] qprod;
  logic [30:0] qrem;
  logic [32:0] rnd;
  logic [16:0] tmag;
  logic signed [63:0] blend, biased;
  assign m2     = p[61:30];
  assign tx     = p[60:30];
  assign q0     = p[62:32];
  assign qprod  = q0 * n_q;
  assign qrem   = x_q - qprod[30:0];
  assign qn     = (qrem >= {27'd0, n_q}) ? q0 + 31'd1 : q0;
  assign rnd    = ({1'b0, sum_q} + 33'h2000) >> 14;
  assign tmag   = dc_q[15] ? 17'(-$signed({dc_q[15], dc_q})) : 17'd0;
  assign blend  = $signed(acc_q) + $signed(p);
  assign biased = blend + 64'sd32768;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frama_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (fill_q < twoh) ? frama_pkg::ST_DONE : frama_pkg::ST_SCAN;
        end
      end
      frama_pkg::ST_SCAN: begin
        if (dv_q && ({1'b0, didx_q} == twoh - 7'd1)) begin
          state_d = frama_pkg::ST_RANGE;
        end
      end
      frama_pkg::ST_RANGE: begin
        state_d = (rf == 33'd0) ? frama_pkg::ST_AVG_A : frama_pkg::ST_DIV_START;
      end
      frama_pkg::ST_DIV_START: state_d = frama_pkg::ST_DIV_WAIT;
      frama_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = frama_pkg::ST_LOG_CLASS;
        end
      end
      frama_pkg::ST_LOG_CLASS: begin
        if (m_q < frama_pkg::OneQ30 || m_q >= frama_pkg::TwoQ30) begin
          state_d = frama_pkg::ST_EXP_MUL;
        end else begin
          state_d = frama_pkg::ST_LOG_MUL;
        end
      end
      frama_pkg::ST_LOG_MUL: state_d = frama_pkg::ST_LOG_UPD;
      frama_pkg::ST_LOG_UPD: begin
        state_d = (it_q == 4'd15) ? frama_pkg::ST_EXP_MUL : frama_pkg::ST_LOG_MUL;
      end
      frama_pkg::ST_EXP_MUL: state_d = frama_pkg::ST_EXP_U;
      frama_pkg::ST_EXP_U:   state_d = frama_pkg::ST_TAY_MUL;
      frama_pkg::ST_TAY_MUL: state_d = frama_pkg::ST_TAY_RCP;
      frama_pkg::ST_TAY_RCP: state_d = frama_pkg::ST_TAY_FIX;
      frama_pkg::ST_TAY_FIX: begin
        state_d = (n_q == frama_pkg::TaylorLast) ? frama_pkg::ST_SQ_MUL
                                                 : frama_pkg::ST_TAY_MUL;
      end
      frama_pkg::ST_SQ_MUL: state_d = frama_pkg::ST_SQ_UPD;
      frama_pkg::ST_SQ_UPD: begin
        state_d = (it_q == 4'd2) ? frama_pkg::ST_ROUND : frama_pkg::ST_SQ_MUL;
      end
      frama_pkg::ST_ROUND:   state_d = frama_pkg::ST_AVG_A;
      frama_pkg::ST_AVG_A:   state_d = frama_pkg::ST_AVG_B;
      frama_pkg::ST_AVG_B:   state_d = frama_pkg::ST_AVG_SUM;
      frama_pkg::ST_AVG_SUM: state_d = frama_pkg::ST_DONE;
      frama_pkg::ST_DONE: begin
        if (!ov_q || m_axis_tready) begin
          state_d = frama_pkg::ST_IDLE;
        end
      end
      default: state_d = frama_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    hp_d = hp_q;  dc_d = dc_q;  fill_d = fill_q;  head_d = head_q;
    cnt_d = cnt_q;  dv_d = 1'b0;  didx_d = didx_q;
    ohm_d = ohm_q;  nhm_d = nhm_q;  olm_d = olm_q;  nlm_d = nlm_q;
    close_d = close_q;  low_d = low_q;  high_d = high_q;
    r_d = r_q;  num_d = num_q;  m_d = m_q;  frac_d = frac_q;  it_d = it_q;
    u_d = u_q;  term_d = term_q;  x_d = x_q;  sum_d = sum_q;  n_d = n_q;
    alpha_d = alpha_q;  acc_d = acc_q;  prev_d = prev_q;
    res_d = res_q;  resu_d = resu_q;
    ov_d = ov_q;  od_d = od_q;  ou_d = ou_q;
    ram_we = 1'b0;  ram_waddr = head_q;  hi_wdata = high_q;  lo_wdata = low_q;
    mul_en = 1'b0;  mul_a = '0;  mul_b = '0;
    div_start = 1'b0;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      frama_pkg::ST_IDLE: begin
        if (in_acc) begin
          close_d = s_axis_tdata[31:0];
          low_d   = s_axis_tdata[63:32];
          high_d  = s_axis_tdata[95:64];
          cnt_d   = '0;
          if (fill_q < twoh) begin
            // Fill: the ring starts at zero, so the bar goes to its fill slot.
            ram_we    = 1'b1;
            ram_waddr = fill_q[Aw-1:0];
            hi_wdata  = s_axis_tdata[95:64];
            lo_wdata  = s_axis_tdata[63:32];
            fill_d    = fill_q + 7'd1;
            prev_d    = s_axis_tdata[31:0];
            res_d     = s_axis_tdata[31:0];
            resu_d    = 1'b0;
          end
        end else if (cfg_we_i) begin
          if (cfg_index_i == frama_pkg::CfgHalfPeriod) begin
            hp_d   = cfg_data_i[5:0];
            fill_d = '0;
            head_d = '0;
          end else if (cfg_index_i == frama_pkg::CfgDecayCoef) begin
            dc_d = cfg_data_i;
          end
        end
      end
      frama_pkg::ST_SCAN: begin
        if (cnt_q < twoh) begin
          dv_d   = 1'b1;
          didx_d = cnt_q[5:0];
          cnt_d  = cnt_q + 7'd1;
        end
        if (dv_q) begin
          // The first h entries from head are the older half-window.
          if (didx_q < h) begin
            if (didx_q == 6'd0 || $signed(hi_rdata) > ohm_q) ohm_d = $signed(hi_rdata);
            if (didx_q == 6'd0 || $signed(lo_rdata) < olm_q) olm_d = $signed(lo_rdata);
          end else begin
            if (didx_q == h || $signed(hi_rdata) > nhm_q) nhm_d = $signed(hi_rdata);
            if (didx_q == h || $signed(lo_rdata) < nlm_q) nlm_d = $signed(lo_rdata);
          end
        end
      end
      frama_pkg::ST_RANGE: begin
        r_d     = rf;
        num_d   = {rsum, 1'b0};
        alpha_d = frama_pkg::AlphaOne;
      end
      frama_pkg::ST_DIV_START: div_start = 1'b1;
      frama_pkg::ST_DIV_WAIT: begin
        if (div_done) m_d = div_quo;
      end
      frama_pkg::ST_LOG_CLASS: begin
        frac_d = (m_q >= frama_pkg::TwoQ30) ? 17'h1_0000 : 17'd0;
        it_d   = '0;
      end
      frama_pkg::ST_LOG_MUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, m_q};
        mul_b  = {1'b0, m_q};
      end
      frama_pkg::ST_LOG_UPD: begin
        frac_d = {frac_q[15:0], m2[31]};
        m_d    = m2[31] ? {1'b0, m2[31:1]} : m2;
        it_d   = it_q + 4'd1;
      end
      frama_pkg::ST_EXP_MUL: begin
        mul_en = 1'b1;
        mul_a  = {16'd0, tmag};
        mul_b  = {16'd0, frac_q};
      end
      frama_pkg::ST_EXP_U: begin
        u_d    = p[31:1];
        term_d = frama_pkg::OneQ30[30:0];
        sum_d  = frama_pkg::OneQ30;
        n_d    = 4'd1;
      end
      frama_pkg::ST_TAY_MUL: begin
        mul_en = 1'b1;
        mul_a  = {2'b0, term_q};
        mul_b  = {2'b0, u_q};
      end
      frama_pkg::ST_TAY_RCP: begin
        x_d    = tx;
        mul_en = 1'b1;
        mul_a  = {2'b0, tx};
        mul_b  = {1'b0, frama_pkg::recip(n_q)};
      end
      frama_pkg::ST_TAY_FIX: begin
        term_d = qn;
        sum_d  = n_q[0] ? sum_q - {1'b0, qn} : sum_q + {1'b0, qn};
        n_d    = n_q + 4'd1;
        it_d   = '0;
      end
      frama_pkg::ST_SQ_MUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, sum_q};
        mul_b  = {1'b0, sum_q};
      end
      frama_pkg::ST_SQ_UPD: begin
        sum_d = m2;
        it_d  = it_q + 4'd1;
      end
      frama_pkg::ST_ROUND: begin
        alpha_d = (rnd > 33'h1_0000) ? frama_pkg::AlphaOne : rnd[16:0];
      end
      frama_pkg::ST_AVG_A: begin
        mul_en = 1'b1;
        mul_a  = {16'd0, alpha_q};
        mul_b  = {close_q[31], close_q};
      end
      frama_pkg::ST_AVG_B: begin
        acc_d  = p;
        mul_en = 1'b1;
        mul_a  = {16'd0, 17'(frama_pkg::AlphaOne - alpha_q)};
        mul_b  = {prev_q[31], prev_q};
      end
      frama_pkg::ST_AVG_SUM: begin
        prev_d = biased[47:16];
        res_d  = biased[47:16];
        resu_d = 1'b1;
        // Oldest bar drops out; the new bar takes its slot at head.
        ram_we = 1'b1;
        head_d = ({1'b0, head_q} + 7'd1 >= twoh) ? '0 : head_q + 6'd1;
      end
      frama_pkg::ST_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          od_d = res_q;
          ou_d = resu_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frama_pkg::ST_IDLE;
      hp_q    <= frama_pkg::HalfReset;
      dc_q    <= frama_pkg::DecayReset;
      fill_q  <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      dv_q    <= 1'b0;
      it_q    <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
      ohm_q   <= '0;
      nhm_q   <= '0;
      olm_q   <= '0;
      nlm_q   <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      hp_q    <= hp_d;
      dc_q    <= dc_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      dv_q    <= dv_d;
      it_q    <= it_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
      ohm_q   <= ohm_d;
      nhm_q   <= nhm_d;
      olm_q   <= olm_d;
      nlm_q   <= nlm_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q  <= didx_d;
    close_q <= close_d;
    low_q   <= low_d;
    high_q  <= high_d;
    r_q     <= r_d;
    num_q   <= num_d;
    m_q     <= m_d;
    frac_q  <= frac_d;
    u_q     <= u_d;
    term_q  <= term_d;
    x_q     <= x_d;
    sum_q   <= sum_d;
    alpha_q <= alpha_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    resu_q  <= resu_d;
    od_q    <= od_d;
    ou_q    <= ou_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;

endmodule
`default_nettype wire
